FILE: hw/rtl/wttq_pkg.sv
// Shared types and constants of the weighted two-level task queue.
// Used by wttq_ctrl, wttq_dp and weighted_two_level_task_queue_core.
package wttq_pkg;

	// Field widths of the beats.
	localparam int ID_W     = 4;
	localparam int CTX_W    = 32;
	localparam int STATUS_W = 3;
	localparam int MASK_W   = 16;
	localparam int TURN_W   = 8;
	localparam int COPY_W   = 7;
	localparam int ENTRY_W  = ID_W + CTX_W;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_IDX_W   = 2;

	localparam logic [COPY_W-1:0] COPY_MAX = 7'd127;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ID  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_TURNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MASK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTI_MASK  = 2'd2;

	// Input mode codes.
	localparam logic MODE_ADD      = 1'b0;
	localparam logic MODE_DISPATCH = 1'b1;

	// Queue levels.
	localparam logic LEVEL_UPPER = 1'b0;
	localparam logic LEVEL_LOWER = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_POP  = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // capture the input beat
		logic exec_add;     // commit an add and post its result
		logic exec_disp;    // pick a level, pop the head pointer, read the entry
		logic finish_disp;  // retire the popped entry and post its result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;         // mode of the captured beat
		logic out_busy;     // output register holds a beat that is not taken
	} sts_t;

endpackage

FILE: hw/rtl/wttq_ctrl.sv
// Sequencer of the weighted two-level task queue.
// Depends on wttq_pkg for the state and command types.
module wttq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  wttq_pkg::sts_t sts,
	output wttq_pkg::cmd_t cmd
);

	wttq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wttq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wttq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = wttq_pkg::S_EXEC;
				end
			end
			wttq_pkg::S_EXEC: begin
				if (sts.mode == wttq_pkg::MODE_DISPATCH) begin
					cmd.exec_disp = 1'b1;
					state_d       = wttq_pkg::S_POP;
				end else if (!sts.out_busy) begin
					cmd.exec_add = 1'b1;
					state_d      = wttq_pkg::S_IDLE;
				end
			end
			wttq_pkg::S_POP: begin
				// hold until the output register can take the result
				if (!sts.out_busy) begin
					cmd.finish_disp = 1'b1;
					state_d         = wttq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = wttq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/wttq_dp.sv
// Datapath of the weighted two-level task queue: configuration, queue memory,
// ring pointers, per-task bookkeeping and the output register. Uses wttq_pkg.
module wttq_dp #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TASK_COUNT  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wttq_pkg::cmd_t                       cmd,
	output wttq_pkg::sts_t                       sts,
	input  logic                                 in_mode,
	input  logic [wttq_pkg::ID_W-1:0]            in_task_id,
	input  logic [wttq_pkg::CTX_W-1:0]           in_context,
	input  logic                                 cfg_we,
	input  logic [wttq_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [wttq_pkg::MASK_W-1:0]          cfg_wdata,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [wttq_pkg::OUT_TDATA_W-1:0]     out_data
);

	localparam int PW         = $clog2(QUEUE_DEPTH);
	localparam int FW         = $clog2(QUEUE_DEPTH + 1);
	localparam int TASK_SLOTS = (TASK_COUNT < 16) ? TASK_COUNT : 16;
	localparam int IW         = $clog2(TASK_SLOTS);
	localparam int MEM_DEPTH  = 2 ** (PW + 1);
	localparam int PAD_W      = wttq_pkg::OUT_TDATA_W - wttq_pkg::STATUS_W - 2
		- wttq_pkg::ID_W - wttq_pkg::CTX_W;

	// captured input beat
	logic                         mode_q;
	logic [wttq_pkg::ID_W-1:0]    tid_q;
	logic [wttq_pkg::CTX_W-1:0]   ctx_q;

	// configuration
	logic [wttq_pkg::TURN_W-1:0]  upper_turns_q;
	logic [wttq_pkg::MASK_W-1:0]  lower_mask_q;
	logic [wttq_pkg::MASK_W-1:0]  multi_mask_q;

	// queue state
	logic [PW-1:0]                head_q [2];
	logic [PW-1:0]                tail_q [2];
	logic [FW-1:0]                fill_q [2];
	logic [wttq_pkg::TURN_W-1:0]  turn_cnt_q;
	logic                         queued_q [TASK_SLOTS];
	logic [wttq_pkg::COPY_W-1:0]  copies_q [TASK_SLOTS];

	logic [wttq_pkg::ENTRY_W-1:0] mem [MEM_DEPTH];
	logic [wttq_pkg::ENTRY_W-1:0] rd_q;
	logic                         got_q;
	logic                         lvl_q;

	logic                         out_valid_q;
	logic [wttq_pkg::OUT_TDATA_W-1:0] out_data_q;

	// add decision
	logic                         add_id_ok, add_multi, add_lvl, add_flag, add_full, add_ok;
	logic [IW-1:0]                add_idx;
	logic [wttq_pkg::STATUS_W-1:0] add_status;

	// dispatch decision
	logic                         pick_lvl, sel_lvl, disp_got;

	// retirement of a popped entry
	logic [wttq_pkg::ID_W-1:0]    gid;
	logic [IW-1:0]                gidx;
	logic                         gid_ok, gid_multi;
	logic [wttq_pkg::COPY_W-1:0]  gid_dec;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		add_id_ok = 32'(tid_q) < TASK_COUNT;
		add_idx   = tid_q[IW-1:0];
		add_multi = multi_mask_q[tid_q];
		add_lvl   = lower_mask_q[tid_q] ? wttq_pkg::LEVEL_LOWER : wttq_pkg::LEVEL_UPPER;
		add_flag  = add_id_ok ? queued_q[add_idx] : 1'b0;
		add_full  = fill_q[add_lvl] == FW'(QUEUE_DEPTH);
		add_ok    = 1'b0;
		if (!add_id_ok) begin
			add_status = wttq_pkg::ST_BAD_ID;
		end else if (add_flag && !add_multi) begin
			add_status = wttq_pkg::ST_ALREADY;
		end else if (add_full) begin
			add_status = wttq_pkg::ST_FULL;
		end else begin
			add_status = wttq_pkg::ST_OK;
			add_ok     = 1'b1;
		end
	end

	always_comb begin
		pick_lvl = (turn_cnt_q >= upper_turns_q) ? wttq_pkg::LEVEL_LOWER
			: wttq_pkg::LEVEL_UPPER;
		// fall back to the other level when the chosen one is empty
		sel_lvl  = (fill_q[pick_lvl] != '0) ? pick_lvl : ~pick_lvl;
		disp_got = fill_q[sel_lvl] != '0;
	end

	always_comb begin
		gid       = rd_q[wttq_pkg::ID_W-1:0];
		gidx      = gid[IW-1:0];
		gid_ok    = got_q && (32'(gid) < TASK_COUNT);
		gid_multi = multi_mask_q[gid];
		gid_dec   = '0;
		if (gid_ok && copies_q[gidx] != '0) begin
			gid_dec = copies_q[gidx] - 1'b1;
		end
	end

	// captured beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			tid_q  <= in_task_id;
			ctx_q  <= in_context;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_turns_q <= 8'd4;
			lower_mask_q  <= 16'd12;
			multi_mask_q  <= 16'd2040;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				wttq_pkg::CFG_UPPER_TURNS: upper_turns_q <= cfg_wdata[wttq_pkg::TURN_W-1:0];
				wttq_pkg::CFG_LOWER_MASK:  lower_mask_q  <= cfg_wdata;
				wttq_pkg::CFG_MULTI_MASK:  multi_mask_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// queue memory: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.exec_add && add_ok) begin
			mem[{add_lvl, tail_q[add_lvl]}] <= {ctx_q, tid_q};
		end
		if (cmd.exec_disp && disp_got) begin
			rd_q <= mem[{sel_lvl, head_q[sel_lvl]}];
		end
	end

	// pointers, fill levels, turn counter and per-task bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 2; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				fill_q[l] <= '0;
			end
			for (int t = 0; t < TASK_SLOTS; t++) begin
				queued_q[t] <= 1'b0;
				copies_q[t] <= '0;
			end
			turn_cnt_q <= '0;
			got_q      <= 1'b0;
			lvl_q      <= 1'b0;
		end else begin
			if (cmd.exec_add && add_ok) begin
				tail_q[add_lvl]   <= ptr_next(tail_q[add_lvl]);
				fill_q[add_lvl]   <= fill_q[add_lvl] + 1'b1;
				queued_q[add_idx] <= 1'b1;
				if (add_multi && copies_q[add_idx] < wttq_pkg::COPY_MAX) begin
					copies_q[add_idx] <= copies_q[add_idx] + 1'b1;
				end
			end
			if (cmd.exec_disp) begin
				// advance the turn counter whether or not anything is served
				if (pick_lvl == wttq_pkg::LEVEL_LOWER) begin
					turn_cnt_q <= '0;
				end else begin
					turn_cnt_q <= turn_cnt_q + 1'b1;
				end
				got_q <= disp_got;
				lvl_q <= sel_lvl;
				if (disp_got) begin
					head_q[sel_lvl] <= ptr_next(head_q[sel_lvl]);
					fill_q[sel_lvl] <= fill_q[sel_lvl] - 1'b1;
				end
			end
			if (cmd.finish_disp && gid_ok) begin
				if (gid_multi) begin
					copies_q[gidx] <= gid_dec;
					if (gid_dec == '0) begin
						queued_q[gidx] <= 1'b0;
					end
				end else begin
					queued_q[gidx] <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec_add || cmd.finish_disp) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_add) begin
			out_data_q <= {PAD_W'(0), 1'b0, wttq_pkg::CTX_W'(0), wttq_pkg::ID_W'(0), 1'b0,
				add_status};
		end else if (cmd.finish_disp) begin
			if (got_q) begin
				out_data_q <= {PAD_W'(0), lvl_q, rd_q[wttq_pkg::ENTRY_W-1:wttq_pkg::ID_W],
					gid, 1'b1, wttq_pkg::ST_OK};
			end else begin
				out_data_q <= {PAD_W'(0), 1'b0, wttq_pkg::CTX_W'(0), wttq_pkg::ID_W'(0),
					1'b0, wttq_pkg::ST_EMPTY};
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign sts.mode     = mode_q;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

FILE: hw/rtl/weighted_two_level_task_queue_core.sv
// Top level of the weighted two-level task queue: stream ports, controller
// and datapath. Depends on wttq_pkg, wttq_ctrl and wttq_dp.
//
// Task dispatcher over two ring FIFOs, upper and lower, each QUEUE_DEPTH
// entries of {task id, 32-bit context}. An add beat (tuser mode 0) enqueues a
// task in the queue its lower_level_mask bit selects; a single-instance task
// already queued is refused, a multi-instance task counts its copies, a full
// queue refuses the beat. A dispatch beat (tuser mode 1) serves the upper
// queue upper_turns times, then the lower queue once, falling back to the
// other queue when the chosen one is empty; the turn counter advances even
// when nothing is served. Every input beat yields exactly one output beat.
// An accepted beat is captured and enters the execute state. An add result is
// loaded into the output register from the execute state, which then presents
// it on m_axis. A dispatch pops the head pointer and reads the queue memory in
// the execute state (registered read port), then retires the entry and posts
// its result from the pop state. One beat is in flight at a time; the next is
// accepted while the previous result still waits in the output register, and
// the add or retire step holds for every cycle that register stays occupied.
// The queue memory is not cleared after reset (entries are only read after
// being written), so the block is ready as soon as reset is released.
// Configuration writes are always taken and must be made only while the
// block is idle.
module weighted_two_level_task_queue_core #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TASK_COUNT  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input beats
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [3:0] task_id, [35:4] task_context, [39:36] zero
	input  logic [wttq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// [0] mode
	input  logic [0:0]                            s_axis_tuser,
	// result beats
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [2:0] status, [3] dispatch_valid, [7:4] out_task_id,
	// [39:8] out_context, [40] served_lower, [47:41] zero
	output logic [wttq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wttq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wttq_pkg::MASK_W-1:0]           cfg_data
);

	wttq_pkg::cmd_t cmd;
	wttq_pkg::sts_t sts;

	// registers are plain flops: take every write
	assign cfg_ready = 1'b1;

	wttq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wttq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_COUNT  (TASK_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (s_axis_tuser[0]),
		.in_task_id (s_axis_tdata[wttq_pkg::ID_W-1:0]),
		.in_context (s_axis_tdata[wttq_pkg::ENTRY_W-1:wttq_pkg::ID_W]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

	// at most one controller command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec_add, cmd.exec_disp, cmd.finish_disp}))
		else $error("controller issued overlapping commands");

	// a result is only posted into a free output register
	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec_add || cmd.finish_disp) |-> !sts.out_busy)
		else $error("result posted over a beat not yet taken");

	// a posted result shows up as a valid beat in the next cycle
	a_post_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec_add || cmd.finish_disp) |=> m_axis_tvalid)
		else $error("posted result not presented");

	// no new beat is taken while a dispatch is still retiring
	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec_disp |=> !s_axis_tready)
		else $error("input accepted during dispatch retirement");

endmodule

FILE: sim/weighted_two_level_task_queue_core_test.sv
`timescale 1ns / 100ps
// Self-checking test of weighted_two_level_task_queue_core: drives add and dispatch beats,
// predicts every result beat in SystemVerilog and compares field by field.
// Depends on wttq_pkg and the core RTL only.
module weighted_two_level_task_queue_core_test;

	localparam int DEPTH = 64;
	localparam int TASKS = 16;
	// Index with no register behind it; writes there must change nothing.
	localparam logic [wttq_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic [wttq_pkg::STATUS_W-1:0] status;
		logic                          dvalid;
		logic [wttq_pkg::ID_W-1:0]     id;
		logic [wttq_pkg::CTX_W-1:0]    ctx;
		logic                          lower;
	} outcome_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [wttq_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]                       s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [wttq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [wttq_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [wttq_pkg::MASK_W-1:0]      cfg_data;

	// Shadow of the dispatcher: registers, both rings, per-task bookkeeping.
	logic [wttq_pkg::TURN_W-1:0] upper_turns_r;
	logic [wttq_pkg::MASK_W-1:0] lower_mask_r;
	logic [wttq_pkg::MASK_W-1:0] multi_mask_r;
	logic [wttq_pkg::ID_W-1:0]   ring_id  [2][DEPTH];
	logic [wttq_pkg::CTX_W-1:0]  ring_ctx [2][DEPTH];
	int unsigned                 q_head [2];
	int unsigned                 q_tail [2];
	int unsigned                 q_fill [2];
	logic [wttq_pkg::TURN_W-1:0] turn_count;
	logic                        task_queued [TASKS];
	logic [wttq_pkg::COPY_W-1:0] copies [TASKS];

	outcome_t due_outcomes[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int recv_hold;

	weighted_two_level_task_queue_core #(
		.QUEUE_DEPTH(DEPTH),
		.TASK_COUNT (TASKS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the shadow by one accepted beat and return the result it must produce.
	function automatic outcome_t step_queues(input logic mode,
			input logic [wttq_pkg::ID_W-1:0] id, input logic [wttq_pkg::CTX_W-1:0] ctx);
		outcome_t r;
		logic lvl;
		logic multi;
		logic [wttq_pkg::ID_W-1:0] gid;
		r = '{status: wttq_pkg::ST_OK, dvalid: 1'b0, id: '0, ctx: '0, lower: 1'b0};
		if (mode == wttq_pkg::MODE_ADD) begin
			multi = multi_mask_r[id];
			lvl = lower_mask_r[id] ? wttq_pkg::LEVEL_LOWER : wttq_pkg::LEVEL_UPPER;
			if (task_queued[id] && !multi) begin
				r.status = wttq_pkg::ST_ALREADY;
			end else if (q_fill[lvl] >= DEPTH) begin
				// a refused add leaves the copy count alone
				r.status = wttq_pkg::ST_FULL;
			end else begin
				ring_id[lvl][q_tail[lvl]] = id;
				ring_ctx[lvl][q_tail[lvl]] = ctx;
				q_tail[lvl] = (q_tail[lvl] + 1) % DEPTH;
				q_fill[lvl]++;
				if (multi && copies[id] < wttq_pkg::COPY_MAX)
					copies[id]++;
				task_queued[id] = 1'b1;
			end
		end else begin
			// the turn counter moves whether or not anything is served
			if (turn_count >= upper_turns_r) begin
				lvl = wttq_pkg::LEVEL_LOWER;
				turn_count = '0;
			end else begin
				lvl = wttq_pkg::LEVEL_UPPER;
				turn_count = turn_count + 8'd1;
			end
			if (q_fill[lvl] == 0)
				lvl = ~lvl;
			if (q_fill[lvl] == 0) begin
				r.status = wttq_pkg::ST_EMPTY;
			end else begin
				gid = ring_id[lvl][q_head[lvl]];
				r.ctx = ring_ctx[lvl][q_head[lvl]];
				q_head[lvl] = (q_head[lvl] + 1) % DEPTH;
				q_fill[lvl]--;
				// the mask as it stands now decides how the task is retired
				if (multi_mask_r[gid]) begin
					if (copies[gid] != 0)
						copies[gid]--;
					if (copies[gid] == 0)
						task_queued[gid] = 1'b0;
				end else begin
					task_queued[gid] = 1'b0;
				end
				r.dvalid = 1'b1;
				r.id = gid;
				r.lower = lvl;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// Compare each taken result beat with the oldest prediction.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_outcomes.size() == 0) begin
				errors++;
				$display("%0t: result beat %h with nothing outstanding, expected none, actual %h",
					$time, m_axis_tdata, m_axis_tdata);
			end else begin
				want = due_outcomes.pop_front();
				check_field("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
				check_field("dispatch_valid", 32'(want.dvalid), 32'(m_axis_tdata[3]));
				check_field("out_task_id", 32'(want.id), 32'(m_axis_tdata[7:4]));
				check_field("out_context", want.ctx, m_axis_tdata[39:8]);
				check_field("served_lower", 32'(want.lower), 32'(m_axis_tdata[40]));
				check_field("pad", 32'd0, 32'(m_axis_tdata[wttq_pkg::OUT_TDATA_W-1:41]));
			end
		end
	end

	// Result side: a long hold-off when asked, random stalls otherwise.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			m_axis_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// Enter and leave at a falling edge; tvalid stays high for a following beat.
	task automatic send_beat(input logic mode, input logic [wttq_pkg::ID_W-1:0] id,
			input logic [wttq_pkg::CTX_W-1:0] ctx);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(wttq_pkg::IN_TDATA_W - wttq_pkg::ID_W - wttq_pkg::CTX_W){1'b0}},
			ctx, id};
		s_axis_tuser <= mode;
		do @(posedge clk); while (!s_axis_tready);
		due_outcomes.push_back(step_queues(mode, id, ctx));
		@(negedge clk);
	endtask

	// Stop offering beats and hold until every result has been taken.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (due_outcomes.size() != 0)
			@(posedge clk);
		// a dispatch retires from the pop state after its pop; give the block time to settle
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [wttq_pkg::CFG_IDX_W-1:0] idx,
			input logic [wttq_pkg::MASK_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wttq_pkg::CFG_UPPER_TURNS: upper_turns_r = value[wttq_pkg::TURN_W-1:0];
			wttq_pkg::CFG_LOWER_MASK:  lower_mask_r = value;
			wttq_pkg::CFG_MULTI_MASK:  multi_mask_r = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Reset registers: 4 upper turns, tasks 2 and 3 lower, tasks 3 to 10 multi-instance.
	task automatic test_directed_basics();
		send_beat(wttq_pkg::MODE_DISPATCH, 4'hF, 32'hFFFF_FFFF);   // both queues empty
		send_beat(wttq_pkg::MODE_ADD, 4'd0, 32'h0000_0000);
		send_beat(wttq_pkg::MODE_ADD, 4'd0, 32'h0000_0001);  // single instance, already queued
		send_beat(wttq_pkg::MODE_ADD, 4'd15, 32'hFFFF_FFFF);
		send_beat(wttq_pkg::MODE_ADD, 4'd2, 32'h5A5A_5A5A);  // single, lower queue
		send_beat(wttq_pkg::MODE_ADD, 4'd3, 32'hA5A5_A5A5);  // multi, lower queue
		send_beat(wttq_pkg::MODE_ADD, 4'd3, 32'h1234_5678);
		send_beat(wttq_pkg::MODE_ADD, 4'd4, 32'h8000_0001);  // multi, upper queue
		send_beat(wttq_pkg::MODE_ADD, 4'd4, 32'h7FFF_FFFE);
		// upper turns, one lower turn, then fallback once upper runs dry
		repeat (8) send_beat(wttq_pkg::MODE_DISPATCH, 4'd0, 32'h0);
	endtask

	// A task keeps its queue after a mask change; retirement follows the new mask.
	task automatic test_mask_change_while_queued();
		drain();
		send_beat(wttq_pkg::MODE_ADD, 4'd5, 32'hC0DE_0001);
		send_beat(wttq_pkg::MODE_ADD, 4'd5, 32'hC0DE_0002);
		send_beat(wttq_pkg::MODE_ADD, 4'd6, 32'hC0DE_0003);
		drain();
		write_reg(wttq_pkg::CFG_MULTI_MASK, 16'h0000);
		write_reg(wttq_pkg::CFG_LOWER_MASK, 16'hFFFF);
		send_beat(wttq_pkg::MODE_DISPATCH, 4'd0, 32'h0);
		send_beat(wttq_pkg::MODE_ADD, 4'd5, 32'hC0DE_0004);  // flag cleared, lands in lower
		send_beat(wttq_pkg::MODE_ADD, 4'd5, 32'hC0DE_0005);  // now single instance
		drain();
		write_reg(wttq_pkg::CFG_MULTI_MASK, 16'd2040);
		write_reg(wttq_pkg::CFG_LOWER_MASK, 16'd12);
		repeat (5) send_beat(wttq_pkg::MODE_DISPATCH, 4'd0, 32'h0);
	endtask

	// Well-formed random traffic under one register setting and one idling style.
	task automatic test_mix(input int count, input int add_pct, input int idle_pct,
			input int stall_pct, input logic [wttq_pkg::MASK_W-1:0] turns,
			input logic [wttq_pkg::MASK_W-1:0] lower, input logic [wttq_pkg::MASK_W-1:0] multi);
		logic mode;
		drain();
		write_reg(wttq_pkg::CFG_UPPER_TURNS, turns);
		write_reg(wttq_pkg::CFG_LOWER_MASK, lower);
		write_reg(wttq_pkg::CFG_MULTI_MASK, multi);
		write_reg(CFG_SPARE, 16'($urandom));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			mode = ($urandom_range(99) < add_pct) ? wttq_pkg::MODE_ADD
				: wttq_pkg::MODE_DISPATCH;
			send_beat(mode, 4'($urandom_range(TASKS - 1)), $urandom);
		end
	endtask

	// Fill both rings with one multi-instance task so its copy count saturates,
	// hit the full queue on each level, then drain everything and two more.
	task automatic test_copy_saturation();
		logic [wttq_pkg::ID_W-1:0] tid;
		tid = 4'($urandom_range(TASKS - 1));
		drain();
		write_reg(wttq_pkg::CFG_MULTI_MASK, 16'hFFFF);
		write_reg(wttq_pkg::CFG_LOWER_MASK, 16'h0000);
		while (q_fill[0] + q_fill[1] != 0)
			send_beat(wttq_pkg::MODE_DISPATCH, 4'($urandom), $urandom);
		repeat (DEPTH + 1) send_beat(wttq_pkg::MODE_ADD, tid, $urandom);
		drain();
		write_reg(wttq_pkg::CFG_LOWER_MASK, 16'hFFFF);
		repeat (DEPTH + 1) send_beat(wttq_pkg::MODE_ADD, tid, $urandom);
		repeat (2 * DEPTH + 2) send_beat(wttq_pkg::MODE_DISPATCH, 4'($urandom), $urandom);
	endtask

	// Hold the result side off long enough that the block stalls its input.
	task automatic test_output_backpressure();
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 300;
		repeat (40)
			send_beat($urandom_range(1) ? wttq_pkg::MODE_ADD : wttq_pkg::MODE_DISPATCH,
				4'($urandom_range(TASKS - 1)), $urandom);
	endtask

	initial begin
		logic [wttq_pkg::MASK_W-1:0] turns;
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		upper_turns_r = 8'd4;
		lower_mask_r = 16'd12;
		multi_mask_r = 16'd2040;
		q_head = '{0, 0};
		q_tail = '{0, 0};
		q_fill = '{0, 0};
		turn_count = '0;
		for (int i = 0; i < TASKS; i++) begin
			task_queued[i] = 1'b0;
			copies[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_basics();
		test_mask_change_while_queued();
		// every dispatch aimed at lower, everything single and upper
		test_mix(220, 60, 0, 0, 16'h0000, 16'h0000, 16'h0000);
		// 255 upper turns, every task lower and multi
		test_mix(220, 55, 61, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		turns = 16'($urandom);
		turns[7:0] = 8'($urandom_range(1, 6));
		test_mix(220, 70, 0, 61, turns, 16'($urandom), 16'($urandom));
		turns = 16'($urandom);
		turns[7:0] = 8'($urandom_range(0, 3));
		test_mix(220, 45, 31, 31, turns, 16'($urandom), 16'($urandom));
		test_copy_saturation();
		test_output_backpressure();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("weighted_two_level_task_queue_core_test: PASS");
		else
			$display("weighted_two_level_task_queue_core_test: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("weighted_two_level_task_queue_core_test: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/wttq_pkg.sv
hw/rtl/wttq_ctrl.sv
hw/rtl/wttq_dp.sv
hw/rtl/weighted_two_level_task_queue_core.sv
sim/weighted_two_level_task_queue_core_test.sv
